// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/dgmp_pkg.sv -----
// Package with types, constants and helpers of the depth grid min-pool block.
`timescale 1ns / 1ps
`default_nettype none

package dgmp_pkg;

    localparam int CELLS = 12;

    typedef logic signed [15:0] dist_t;
    typedef logic [CELLS-1:0][15:0] min_vec_t;
    typedef logic [3:0] cell_idx_t;
    typedef logic [5:0] sample_idx_t;
    typedef logic [7:0] angle_t;

    localparam dist_t MIN_INIT = 16'sh7FFF;
    localparam sample_idx_t LAST_SAMPLE = 6'd63;
    localparam cell_idx_t LAST_CELL = 4'd11;
    localparam logic [1:0] LAST_ROW = 2'd3;
    localparam logic [1:0] LAST_COLUMN = 2'd2;

    // Grid cell that steers the servo: row 1, column 2.
    localparam cell_idx_t SERVO_CELL = 4'd5;

    // Angle mapping: 100 mm gives 180 degrees, 1500 mm gives 0 degrees.
    localparam dist_t NEAR_MM = 16'sd100;
    localparam dist_t FAR_MM = 16'sd1500;
    localparam angle_t ANGLE_MAX = 8'd180;
    // Below this offset from the near limit the quotient truncates to zero.
    localparam logic signed [16:0] NEAR_DEAD = 17'sd8;
    // floor(x / 70) equals (x * RECIP) >> RECIP_SHIFT for every x below 12600.
    localparam logic [14:0] RECIP = 15'd14980;
    localparam int RECIP_SHIFT = 20;

    // Maps a frame sample index to its grid cell in row-major grid order.
    function automatic cell_idx_t cell_of(input sample_idx_t idx);
        logic [1:0] row;
        logic [1:0] col;
        begin
            row = idx[5:4];
            if (idx[2:0] < 3'd2)
            begin
                col = 2'd2;
            end
            else if (idx[2:0] < 3'd6)
            begin
                col = 2'd1;
            end
            else
            begin
                col = 2'd0;
            end
            cell_of = {row, 1'b0} + {2'b00, row} + {2'b00, col};
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/dgmp_if.sv -----
// Stream interfaces for the sample input and the grid result output.
`timescale 1ns / 1ps
`default_nettype none

interface dgmp_sample_if;
    import dgmp_pkg::*;

    logic valid;
    logic ready;
    dist_t distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

interface dgmp_result_if;
    import dgmp_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] cell_row;
    logic [1:0] cell_column;
    dist_t cell_min;
    angle_t servo_angle;
    logic last_cell;

    modport source (output valid, output cell_row, output cell_column, output cell_min,
                    output servo_angle, output last_cell, input ready);
    modport sink (input valid, input cell_row, input cell_column, input cell_min,
                  input servo_angle, input last_cell, output ready);
endinterface

`default_nettype wire

// ----- src/depth_grid_min_pool_servo_core.sv -----
// Top level of the depth grid min-pool block with servo angle output.
//
// The samples channel takes the 64 distance samples of an 8x8 frame in
// row-major order, one request per cycle. Each sample updates the minimum of
// its cell in a 4-row by 3-column grid in the cycle it is accepted.
// The sample that closes a frame copies the twelve minima and the servo angle
// into a result bank and clears the live minima, so the next frame can start
// in the following cycle.
// The results channel then sends the twelve cells in row-major grid order,
// one per cycle unless stalled, the first via the bank and output register;
// last_cell marks the twelfth. The angle comes from the row 1, column 2
// minimum through a two-stage pipeline that settles long before the frame
// closes. Throughput is one sample per cycle. The closing sample of a frame
// is held off only while the bank still holds cells of the previous frame.
// When the receiver stalls, the output register holds its request and the
// bank drains once the receiver is ready again.
// Reset clears the sample counter, sets all minima to 32767 and empties the
// bank and the output register.
`timescale 1ns / 1ps
`default_nettype none

module depth_grid_min_pool_servo_core
    import dgmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    dgmp_sample_if.sink   samples,
    dgmp_result_if.source results
);

    min_vec_t minima;
    min_vec_t frame_min;
    logic     frame_done;
    logic     bank_busy;
    angle_t   angle;

    dgmp_pool u_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .bank_busy  (bank_busy),
        .minima     (minima),
        .frame_min  (frame_min),
        .frame_done (frame_done)
    );

    dgmp_servo u_servo (
        .clk       (clk),
        .rst_n     (rst_n),
        .steer_min (dist_t'(minima[SERVO_CELL])),
        .angle     (angle)
    );

    dgmp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_min  (frame_min),
        .frame_done (frame_done),
        .angle      (angle),
        .bank_busy  (bank_busy),
        .results    (results)
    );

endmodule

`default_nettype wire

// ----- src/dgmp_pool.sv -----
// Sample counter and per-cell running minima of the depth frame.
`timescale 1ns / 1ps
`default_nettype none

module dgmp_pool
    import dgmp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dgmp_sample_if.sink samples,
    input  wire logic   bank_busy,
    output min_vec_t    minima,
    output min_vec_t    frame_min,
    output logic        frame_done
);

    sample_idx_t idx_reg;
    sample_idx_t idx_next;
    min_vec_t    min_reg;
    min_vec_t    min_next;
    cell_idx_t   cell_sel;
    logic        accept;

    // The last sample of a frame waits until the result bank is free.
    assign samples.ready = !((idx_reg == LAST_SAMPLE) && bank_busy);
    assign accept = samples.valid && samples.ready;
    assign cell_sel = cell_of(idx_reg);
    assign frame_done = accept && (idx_reg == LAST_SAMPLE);
    assign minima = min_reg;

    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            if (accept && (cell_sel == cell_idx_t'(i)) &&
                (samples.distance < $signed(min_reg[i])))
            begin
                frame_min[i] = samples.distance;
            end
            else
            begin
                frame_min[i] = min_reg[i];
            end
            min_next[i] = frame_done ? MIN_INIT : frame_min[i];
        end
        idx_next = accept ? idx_reg + 6'd1 : idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int i = 0; i < CELLS; i++)
            begin
                min_reg[i] <= MIN_INIT;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            min_reg <= min_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dgmp_servo.sv -----
// Two-stage pipeline that maps the steering cell minimum to a servo angle.
`timescale 1ns / 1ps
`default_nettype none

module dgmp_servo
    import dgmp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  dist_t     steer_min,
    output angle_t    angle
);

    logic signed [16:0] offset;
    logic [13:0] scaled_reg;
    logic [13:0] scaled_next;
    logic        near_reg;
    logic        near_next;
    logic        far_reg;
    logic        far_next;
    logic [28:0] product;
    angle_t      quotient;
    angle_t      angle_reg;
    angle_t      angle_next;

    // Stage one: clamp decisions and the offset times nine.
    always_comb
    begin
        offset = 17'(steer_min) - 17'(NEAR_MM);
        near_next = offset < NEAR_DEAD;
        far_next = steer_min >= FAR_MM;
        scaled_next = {3'b000, offset[10:0]} + {offset[10:0], 3'b000};
    end

    // Stage two: divide by seventy through the reciprocal and subtract.
    always_comb
    begin
        product = 29'(scaled_reg) * 29'(RECIP);
        quotient = product[RECIP_SHIFT +: 8];
        if (near_reg)
        begin
            angle_next = ANGLE_MAX;
        end
        else if (far_reg)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = ANGLE_MAX - quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= 1'b1;
            far_reg <= 1'b0;
            angle_reg <= ANGLE_MAX;
        end
        else
        begin
            near_reg <= near_next;
            far_reg <= far_next;
            angle_reg <= angle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// ----- src/dgmp_emit.sv -----
// Result bank and output register that send the twelve cells of a frame.
`timescale 1ns / 1ps
`default_nettype none

module dgmp_emit
    import dgmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  min_vec_t      frame_min,
    input  wire logic     frame_done,
    input  angle_t        angle,
    output logic          bank_busy,
    dgmp_result_if.source results
);

    min_vec_t   bank_reg;
    angle_t     angle_hold_reg;
    logic       busy_reg;
    logic       busy_next;
    cell_idx_t  cnt_reg;
    cell_idx_t  cnt_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] out_row_reg;
    logic [1:0] out_col_reg;
    dist_t      out_min_reg;
    angle_t     out_angle_reg;
    logic       out_last_reg;
    logic       load;

    // A pending bank cell goes to the output register when it is empty or being taken.
    assign load = busy_reg && (!valid_reg || results.ready);
    assign bank_busy = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        row_next = row_reg;
        col_next = col_reg;
        valid_next = valid_reg && !results.ready;
        if (frame_done)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            row_next = '0;
            col_next = '0;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            cnt_next = cnt_reg + 4'd1;
            if (col_reg == LAST_COLUMN)
            begin
                col_next = '0;
                row_next = row_reg + 2'd1;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
            if (cnt_reg == LAST_CELL)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            row_reg <= row_next;
            col_reg <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            bank_reg <= frame_min;
            angle_hold_reg <= angle;
        end
        if (load)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_min_reg <= bank_reg[cnt_reg];
            out_angle_reg <= angle_hold_reg;
            out_last_reg <= (cnt_reg == LAST_CELL);
        end
    end

    assign results.valid = valid_reg;
    assign results.cell_row = out_row_reg;
    assign results.cell_column = out_col_reg;
    assign results.cell_min = out_min_reg;
    assign results.servo_angle = out_angle_reg;
    assign results.last_cell = out_last_reg;

endmodule

`default_nettype wire

// ----- src/dgmp_checker.sv -----
// Port-level checker for the depth grid min-pool block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dgmp_checker
    import dgmp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] cell_row,
    input wire logic [1:0] cell_column,
    input wire dist_t      cell_min,
    input wire angle_t     servo_angle,
    input wire logic       last_cell
);

    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cell_min) && $stable(cell_row) && $stable(cell_column))
    `ASSERT_SAME(a_last_pos, clk, rst_n, out_valid && last_cell, cell_row == LAST_ROW && cell_column == LAST_COLUMN)
    `ASSERT_SAME(a_angle_range, clk, rst_n, out_valid, servo_angle <= ANGLE_MAX)
    `ASSERT_SAME(a_column_range, clk, rst_n, out_valid, cell_column != 2'd3)

endmodule

bind depth_grid_min_pool_servo_core dgmp_checker u_dgmp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .cell_row    (results.cell_row),
    .cell_column (results.cell_column),
    .cell_min    (results.cell_min),
    .servo_angle (results.servo_angle),
    .last_cell   (results.last_cell)
);

`default_nettype wire

// ----- tb/tb_depth_grid_min_pool_servo_core.sv -----
// Self-checking testbench for the depth grid min-pool core with servo angle output.
`timescale 1ns / 1ps

import dgmp_pkg::*;

typedef struct {
    logic [1:0] row;
    logic [1:0] column;
    dist_t      min_dist;
    angle_t     angle;
    logic       last;
} grid_cell_t;

class pool_scoreboard;
    localparam int GRID_ROWS = 4;
    localparam int GRID_COLS = 3;

    int          minima[CELLS];
    sample_idx_t sample_idx;
    grid_cell_t  pending_cells[$];
    int          errors;

    function new();
        clear_minima();
        sample_idx = '0;
        errors = 0;
    endfunction

    function void clear_minima();
        foreach (minima[i])
        begin
            minima[i] = int'(MIN_INIT);
        end
    endfunction

    function int servo_angle_of(input int m);
        int a;
        begin
            a = ((m - int'(NEAR_MM)) * (0 - int'(ANGLE_MAX))) / (int'(FAR_MM) - int'(NEAR_MM))
                + int'(ANGLE_MAX);
            if (a < 0)
            begin
                a = 0;
            end
            if (a > int'(ANGLE_MAX))
            begin
                a = int'(ANGLE_MAX);
            end
            return a;
        end
    endfunction

    // Folds one accepted sample into the grid and queues the frame's cells on its last sample.
    function void note_sample(input dist_t d);
        int         grid_row;
        int         grid_col;
        int         cell_pos;
        int         angle;
        grid_cell_t e;
        begin
            grid_row = int'(sample_idx[5:4]);
            if (sample_idx[2:0] < 3'd2)
            begin
                grid_col = 2;
            end
            else if (sample_idx[2:0] < 3'd6)
            begin
                grid_col = 1;
            end
            else
            begin
                grid_col = 0;
            end
            cell_pos = grid_row * GRID_COLS + grid_col;
            if (int'(d) < minima[cell_pos])
            begin
                minima[cell_pos] = int'(d);
            end
            if (sample_idx == LAST_SAMPLE)
            begin
                angle = servo_angle_of(minima[int'(SERVO_CELL)]);
                for (int r = 0; r < GRID_ROWS; r++)
                begin
                    for (int c = 0; c < GRID_COLS; c++)
                    begin
                        e.row = 2'(r);
                        e.column = 2'(c);
                        e.min_dist = 16'(minima[r * GRID_COLS + c]);
                        e.angle = 8'(angle);
                        e.last = (r == GRID_ROWS - 1) && (c == GRID_COLS - 1);
                        pending_cells.push_back(e);
                    end
                end
                clear_minima();
            end
            sample_idx = sample_idx + 6'd1;
        end
    endfunction

    function void check_cell(input grid_cell_t got);
        grid_cell_t e;
        begin
            if (pending_cells.size() == 0)
            begin
                $error("unexpected result: row %0d column %0d min %0d", got.row, got.column,
                       got.min_dist);
                errors++;
                return;
            end
            e = pending_cells.pop_front();
            if (got.row !== e.row)
            begin
                $error("cell_row: expected %0d, actual %0d", e.row, got.row);
                errors++;
            end
            if (got.column !== e.column)
            begin
                $error("cell_column: expected %0d, actual %0d", e.column, got.column);
                errors++;
            end
            if (got.min_dist !== e.min_dist)
            begin
                $error("cell_min: expected %0d, actual %0d", e.min_dist, got.min_dist);
                errors++;
            end
            if (got.angle !== e.angle)
            begin
                $error("servo_angle: expected %0d, actual %0d", e.angle, got.angle);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last_cell: expected %0d, actual %0d", e.last, got.last);
                errors++;
            end
        end
    endfunction

    function int outstanding();
        return pending_cells.size();
    endfunction
endclass

module tb_depth_grid_min_pool_servo_core;

    localparam int FRAME_LEN = 64;
    localparam int OPENING_LEN = 25;
    localparam int RANDOM_FRAMES = 1;
    localparam int HOLD_OFF_CYCLES = 700;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    dgmp_sample_if samples_if ();
    dgmp_result_if results_if ();

    pool_scoreboard sb;

    // Opening samples hit the range limits, the angle break points and mixed bit patterns.
    // Samples after them stay at 32767, so the lower grid rows report the cleared value.
    dist_t opening[OPENING_LEN] = '{
        -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd21845, -16'sd32767, 16'sd10922,
        -16'sd21846, 16'sd200, 16'sd500, 16'sd499, 16'sd32767, 16'sd32766, -16'sd2, 16'sd12345,
        16'sd107, 16'sd1500, 16'sd100, 16'sd99, 16'sd1501, -16'sd100, 16'sd7, 16'sd32767,
        16'sd108
    };

    always #10 clk = ~clk;

    depth_grid_min_pool_servo_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    // Gap before the next request, with occasional runs of back-to-back requests.
    function automatic int draw_gap(inout int calm_left);
        begin
            if (calm_left > 0)
            begin
                calm_left--;
                return 0;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                calm_left = $urandom_range(8, 40);
                return 0;
            end
            return $urandom_range(0, 3);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic drive_sample(input dist_t d, input int gap);
        begin
            if (gap > 0)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            samples_if.valid <= 1'b1;
            samples_if.distance <= d;
            @(posedge clk);
            while (!samples_if.ready)
            begin
                @(posedge clk);
            end
            sb.note_sample(d);
            @(negedge clk);
        end
    endtask

    task automatic receive_cells();
        int         calm_left;
        int         gap;
        int         cells_seen;
        bit         held;
        grid_cell_t got;
        begin
            calm_left = 0;
            cells_seen = 0;
            held = 1'b0;
            forever
            begin
                gap = draw_gap(calm_left);
                // Before the first cell is taken, stall long enough for the second frame
                // to back up behind the first one and hold off its closing sample.
                if (!held && cells_seen == 0)
                begin
                    gap = HOLD_OFF_CYCLES;
                    held = 1'b1;
                end
                if (gap > 0)
                begin
                    results_if.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                results_if.ready <= 1'b1;
                @(posedge clk);
                while (!results_if.valid)
                begin
                    @(posedge clk);
                end
                got.row = results_if.cell_row;
                got.column = results_if.cell_column;
                got.min_dist = results_if.cell_min;
                got.angle = results_if.servo_angle;
                got.last = results_if.last_cell;
                sb.check_cell(got);
                cells_seen++;
                @(negedge clk);
            end
        end
    endtask

    // Sample for frame position k; the servo cell stays close above the frame's target.
    function automatic dist_t random_sample(input int k, input int target, input int hit,
                                            input int style);
        int v;
        begin
            if ((k / 16) == 1 && (k % 8) < 2)
            begin
                if (k == hit)
                begin
                    v = target;
                end
                else
                begin
                    v = target + $urandom_range(0, 300);
                end
                if (v > int'(MIN_INIT))
                begin
                    v = int'(MIN_INIT);
                end
                return 16'(v);
            end
            if (style == 0 && $urandom_range(0, 7) != 0)
            begin
                return MIN_INIT;
            end
            case ($urandom_range(0, 7))
                0: return $urandom_range(0, 1) ? MIN_INIT : -16'sd32768;
                1, 2, 3: return 16'($urandom);
                default: return 16'($urandom_range(0, 4000));
            endcase
        end
    endfunction

    initial
    begin : stimulus
        int calm_left;
        int target;
        int hit;
        int style;
        dist_t d;
        rst_n = 1'b0;
        samples_if.valid = 1'b0;
        samples_if.distance = '0;
        results_if.ready = 1'b0;
        calm_left = 0;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        fork
            receive_cells();
        join_none

        for (int k = 0; k < FRAME_LEN; k++)
        begin
            d = (k < OPENING_LEN) ? opening[k] : MIN_INIT;
            drive_sample(d, draw_gap(calm_left));
        end

        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            case ($urandom_range(0, 9))
                0: target = int'(NEAR_MM);
                1: target = int'(FAR_MM);
                2: target = int'(NEAR_MM) - 1;
                3: target = int'(FAR_MM) + 1;
                4: target = int'(NEAR_MM) + 7;
                5: target = int'(NEAR_MM) + 8;
                6: target = -32768;
                7: target = int'(MIN_INIT);
                default: target = $urandom_range(0, 1700);
            endcase
            case ($urandom_range(0, 3))
                0: hit = 16;
                1: hit = 17;
                2: hit = 24;
                default: hit = 25;
            endcase
            style = $urandom_range(0, 3);
            for (int k = 0; k < FRAME_LEN; k++)
            begin
                drive_sample(random_sample(k, target, hit, style), draw_gap(calm_left));
            end
        end
        samples_if.valid <= 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb_depth_grid_min_pool_servo_core: PASS");
        end
        else
        begin
            $display("tb_depth_grid_min_pool_servo_core: FAIL");
        end
        $finish;
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("tb_depth_grid_min_pool_servo_core: FAIL");
        $finish;
    end

endmodule
